>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the keyed delay queue checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define KDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kdq_pkg.sv
// ---------------------------------------------------------------------------
// Keyed delay queue package
// Widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package kdq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned WAIT_W   = 20;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned ENTRY_W  = KEY_W + TAG_W + TIME_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK            = 3'd0,
    OP_ADD             = 3'd1,
    OP_ADD_ABSENT      = 3'd2,
    OP_REPLACE_KEY     = 3'd3,
    OP_REPLACE_KEY_TAG = 3'd4,
    OP_REMOVE_KEY      = 3'd5,
    OP_REMOVE_KEY_TAG  = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_REMOVED = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DISPATCH = 1'b0,
    KIND_STATUS   = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CNT_RD,
    S_CNT_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_EV,
    S_INS_WR,
    S_STAT
  } state_e;

  typedef struct packed {
    logic load;
    logic cnt_rd;
    logic cnt_ev;
    logic scan_start;
    logic scan_rd;
    logic scan_ev;
    logic scan_end;
    logic decide;
    logic shift_rd;
    logic shift_ev;
    logic ins_wr;
    logic stat;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic op_valid;
    logic do_insert;
    logic rd_done;
    logic due;
    logic emit;
    logic out_busy;
    logic shift_done;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/keyed_delay_queue_core.sv
// ---------------------------------------------------------------------------
// Keyed delay queue core
// Due-time sorted queue of (key, tag, due) entries with a tick-driven clock.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_* channel (valid/stall); one word carries op,
//   wait_time, contact_key and param_tag. Results leave on the out_* channel.
//   A tick yields one dispatch word per due entry (none if nothing is due);
//   every other valid op yields one status word. Unused op codes are dropped.
//   last_o marks the final word of a request.
//   One request is worked on at a time. Entries are visited one at a time
//   through the entry RAM's single read and single write port: a scan visit
//   reads an entry, then writes it back unless it is removed or dispatched.
//   An insert then moves the later entries up one place to open its slot.
//   Reset empties the queue and zeroes the time counter; RAM contents are
//   left as they are and only entries below the fill count are ever read.
//   When the receiver stalls, the result word holds and the scan pauses at
//   the next word to be sent; in_stall_o stays high until the request is done.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_delay_queue_core #(
  parameter int unsigned QUEUE_DEPTH = kdq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [kdq_pkg::OP_W-1:0]      op_i,
  input  wire logic [kdq_pkg::WAIT_W-1:0]    wait_time_i,
  input  wire logic [kdq_pkg::KEY_W-1:0]     contact_key_i,
  input  wire logic [kdq_pkg::TAG_W-1:0]     param_tag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               kind_o,
  output logic      [kdq_pkg::KEY_W-1:0]     out_key_o,
  output logic      [kdq_pkg::TAG_W-1:0]     out_tag_o,
  output logic      [kdq_pkg::STATUS_W-1:0]  status_o,
  output logic      [kdq_pkg::COUNT_W-1:0]   removed_count_o,
  output logic      [kdq_pkg::COUNT_W-1:0]   occupancy_o,
  output logic                               last_o
);

  kdq_pkg::ctrl_cmd_t  cmd;
  kdq_pkg::dp_status_t st;

  kdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  kdq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .op_i            (op_i),
    .wait_time_i     (wait_time_i),
    .contact_key_i   (contact_key_i),
    .param_tag_i     (param_tag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_key_o       (out_key_o),
    .out_tag_o       (out_tag_o),
    .status_o        (status_o),
    .removed_count_o (removed_count_o),
    .occupancy_o     (occupancy_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

>>> hdl/kdq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module kdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/kdq_ctrl.sv
// ---------------------------------------------------------------------------
// Keyed delay queue controller
// Sequences the count, scan, shift, insert and status phases of a request.
// ---------------------------------------------------------------------------
`default_nettype none

module kdq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire kdq_pkg::dp_status_t st_i,
  output kdq_pkg::ctrl_cmd_t      cmd_o
);

  kdq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kdq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = kdq_pkg::S_START;
      end
      kdq_pkg::S_START: begin
        if (!st_i.op_valid)    state_d = kdq_pkg::S_IDLE;
        else if (st_i.op_tick) state_d = kdq_pkg::S_CNT_RD;
        else                   state_d = kdq_pkg::S_SCAN_RD;
      end
      kdq_pkg::S_CNT_RD: begin
        state_d = st_i.rd_done ? kdq_pkg::S_SCAN_RD : kdq_pkg::S_CNT_EV;
      end
      kdq_pkg::S_CNT_EV: begin
        state_d = st_i.due ? kdq_pkg::S_CNT_RD : kdq_pkg::S_SCAN_RD;
      end
      kdq_pkg::S_SCAN_RD: begin
        if (!st_i.rd_done)     state_d = kdq_pkg::S_SCAN_EV;
        else if (st_i.op_tick) state_d = kdq_pkg::S_IDLE;
        else                   state_d = kdq_pkg::S_DECIDE;
      end
      kdq_pkg::S_SCAN_EV: begin
        if (!(st_i.emit && st_i.out_busy)) state_d = kdq_pkg::S_SCAN_RD;
      end
      kdq_pkg::S_DECIDE: begin
        state_d = st_i.do_insert ? kdq_pkg::S_SHIFT_RD : kdq_pkg::S_STAT;
      end
      kdq_pkg::S_SHIFT_RD: begin
        state_d = st_i.shift_done ? kdq_pkg::S_INS_WR : kdq_pkg::S_SHIFT_EV;
      end
      kdq_pkg::S_SHIFT_EV: state_d = kdq_pkg::S_SHIFT_RD;
      kdq_pkg::S_INS_WR:   state_d = kdq_pkg::S_STAT;
      kdq_pkg::S_STAT: begin
        if (!st_i.out_busy) state_d = kdq_pkg::S_IDLE;
      end
      default: state_d = kdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != kdq_pkg::S_IDLE);
    case (state_q)
      kdq_pkg::S_IDLE:     cmd_o.load = in_valid_i;
      kdq_pkg::S_START:    cmd_o = '0;
      kdq_pkg::S_CNT_RD: begin
        cmd_o.cnt_rd     = !st_i.rd_done;
        cmd_o.scan_start = st_i.rd_done;
      end
      kdq_pkg::S_CNT_EV: begin
        cmd_o.cnt_ev     = st_i.due;
        cmd_o.scan_start = !st_i.due;
      end
      kdq_pkg::S_SCAN_RD: begin
        cmd_o.scan_rd  = !st_i.rd_done;
        cmd_o.scan_end = st_i.rd_done;
      end
      kdq_pkg::S_SCAN_EV:  cmd_o.scan_ev  = !(st_i.emit && st_i.out_busy);
      kdq_pkg::S_DECIDE:   cmd_o.decide   = 1'b1;
      kdq_pkg::S_SHIFT_RD: cmd_o.shift_rd = !st_i.shift_done;
      kdq_pkg::S_SHIFT_EV: cmd_o.shift_ev = 1'b1;
      kdq_pkg::S_INS_WR:   cmd_o.ins_wr   = 1'b1;
      kdq_pkg::S_STAT:     cmd_o.stat     = !st_i.out_busy;
      default:             cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/kdq_dp.sv
// ---------------------------------------------------------------------------
// Keyed delay queue datapath
// Entry RAM, scan pointers, due-time compares and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module kdq_dp #(
  parameter int unsigned QUEUE_DEPTH = kdq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kdq_pkg::ctrl_cmd_t            cmd_i,
  output kdq_pkg::dp_status_t                st_o,
  input  wire logic [kdq_pkg::OP_W-1:0]      op_i,
  input  wire logic [kdq_pkg::WAIT_W-1:0]    wait_time_i,
  input  wire logic [kdq_pkg::KEY_W-1:0]     contact_key_i,
  input  wire logic [kdq_pkg::TAG_W-1:0]     param_tag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               kind_o,
  output logic      [kdq_pkg::KEY_W-1:0]     out_key_o,
  output logic      [kdq_pkg::TAG_W-1:0]     out_tag_o,
  output logic      [kdq_pkg::STATUS_W-1:0]  status_o,
  output logic      [kdq_pkg::COUNT_W-1:0]   removed_count_o,
  output logic      [kdq_pkg::COUNT_W-1:0]   occupancy_o,
  output logic                               last_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = kdq_pkg::TIME_W;

  logic [kdq_pkg::OP_W-1:0]  op_q;
  logic [kdq_pkg::KEY_W-1:0] key_q;
  logic [kdq_pkg::TAG_W-1:0] tag_q;
  logic [TW-1:0]             new_due_q;
  logic [TW-1:0]             now_q;
  logic [CW-1:0]             cnt_q, r_q, w_q, n_q, pos_q, removed_q;
  logic                      key_found_q, pos_found_q;
  kdq_pkg::status_e          status_q, status_d;

  logic                           out_valid_q;
  kdq_pkg::kind_e                 kind_q;
  logic [kdq_pkg::KEY_W-1:0]      okey_q;
  logic [kdq_pkg::TAG_W-1:0]      otag_q;
  kdq_pkg::status_e               ostatus_q;
  logic [kdq_pkg::COUNT_W-1:0]    oremoved_q, oocc_q;
  logic                           olast_q;

  logic [kdq_pkg::ENTRY_W-1:0] rdata, wdata;
  logic                        we, re;
  logic [IW-1:0]               waddr, raddr;
  logic [CW-1:0]               r_dec;

  logic [kdq_pkg::KEY_W-1:0] rd_key;
  logic [kdq_pkg::TAG_W-1:0] rd_tag;
  logic [TW-1:0]             rd_due, d_now, d_new;
  logic                      is_due, is_later, key_match, tag_match, hit, emit;
  logic                      op_tick, op_valid, op_add, op_cond, op_rm_key, op_rm_kt;
  logic                      full, do_insert, load_disp;

  assign rd_key = rdata[kdq_pkg::ENTRY_W-1 -: kdq_pkg::KEY_W];
  assign rd_tag = rdata[kdq_pkg::TAG_W+TW-1 -: kdq_pkg::TAG_W];
  assign rd_due = rdata[TW-1:0];

  assign d_now    = rd_due - now_q;
  assign d_new    = rd_due - new_due_q;
  assign is_due   = (d_now == '0) || d_now[TW-1];
  assign is_later = (d_new != '0) && !d_new[TW-1];

  assign op_tick   = (op_q == kdq_pkg::OP_TICK);
  assign op_valid  = (op_q <= kdq_pkg::OP_REMOVE_KEY_TAG);
  assign op_add    = (op_q >= kdq_pkg::OP_ADD) && (op_q <= kdq_pkg::OP_REPLACE_KEY_TAG);
  assign op_cond   = (op_q == kdq_pkg::OP_ADD_ABSENT);
  assign op_rm_key = (op_q == kdq_pkg::OP_REPLACE_KEY) || (op_q == kdq_pkg::OP_REMOVE_KEY);
  assign op_rm_kt  = (op_q == kdq_pkg::OP_REPLACE_KEY_TAG) ||
                     (op_q == kdq_pkg::OP_REMOVE_KEY_TAG);

  assign key_match = (rd_key == key_q);
  assign tag_match = (rd_tag == tag_q);
  assign hit  = op_tick ? (r_q < n_q)
                        : ((op_rm_key && key_match) || (op_rm_kt && key_match && tag_match));
  assign emit = op_tick && hit;

  assign full      = (cnt_q >= CW'(QUEUE_DEPTH));
  assign do_insert = op_add && !(op_cond && key_found_q) && !full;

  always_comb begin
    if (!op_add)                        status_d = kdq_pkg::ST_REMOVED;
    else if (op_cond && key_found_q)    status_d = kdq_pkg::ST_PRESENT;
    else if (full)                      status_d = kdq_pkg::ST_FULL;
    else                                status_d = kdq_pkg::ST_ADDED;
  end

  assign st_o.op_tick    = op_tick;
  assign st_o.op_valid   = op_valid;
  assign st_o.do_insert  = do_insert;
  assign st_o.rd_done    = (r_q >= cnt_q);
  assign st_o.due        = is_due;
  assign st_o.emit       = emit;
  assign st_o.out_busy   = out_valid_q && out_stall_i;
  assign st_o.shift_done = (r_q == pos_q);

  // entry RAM ports
  assign r_dec = r_q - CW'(1);
  assign re    = cmd_i.cnt_rd || cmd_i.scan_rd || cmd_i.shift_rd;
  assign raddr = cmd_i.shift_rd ? r_dec[IW-1:0] : r_q[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = r_q[IW-1:0];
    wdata = rdata;
    if (cmd_i.scan_ev && !hit) begin
      we    = 1'b1;
      waddr = w_q[IW-1:0];
    end
    if (cmd_i.shift_ev) begin
      we    = 1'b1;
      waddr = r_q[IW-1:0];
    end
    if (cmd_i.ins_wr) begin
      we    = 1'b1;
      waddr = pos_q[IW-1:0];
      wdata = {key_q, tag_q, new_due_q};
    end
  end

  kdq_ram #(
    .WIDTH (kdq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      cnt_q       <= '0;
      r_q         <= '0;
      w_q         <= '0;
      n_q         <= '0;
      removed_q   <= '0;
      key_found_q <= 1'b0;
      pos_found_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (op_i == kdq_pkg::OP_TICK) now_q <= now_q + TW'(1);
        r_q         <= '0;
        w_q         <= '0;
        n_q         <= '0;
        removed_q   <= '0;
        key_found_q <= 1'b0;
        pos_found_q <= 1'b0;
      end
      if (cmd_i.cnt_ev) begin
        n_q <= n_q + CW'(1);
        r_q <= r_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        r_q <= '0;
        w_q <= '0;
      end
      if (cmd_i.scan_ev) begin
        r_q <= r_q + CW'(1);
        if (hit) removed_q <= removed_q + CW'(1);
        else     w_q       <= w_q + CW'(1);
        if (!hit && !pos_found_q && is_later) pos_found_q <= 1'b1;
        if (key_match) key_found_q <= 1'b1;
      end
      if (cmd_i.scan_end) begin
        cnt_q <= w_q;
        r_q   <= w_q;
      end
      if (cmd_i.shift_ev) r_q <= r_dec;
      if (cmd_i.ins_wr) cnt_q <= cnt_q + CW'(1);
    end
  end

  // request payload, insert position and status
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      key_q     <= contact_key_i;
      tag_q     <= param_tag_i;
      new_due_q <= now_q + TW'(wait_time_i);
    end
    if (cmd_i.scan_ev && !hit && !pos_found_q && is_later) pos_q <= w_q;
    if (cmd_i.scan_end && !pos_found_q) pos_q <= w_q;
    if (cmd_i.decide) status_q <= status_d;
  end

  // result register
  assign load_disp = cmd_i.scan_ev && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_disp || cmd_i.stat) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_disp) begin
      kind_q     <= kdq_pkg::KIND_DISPATCH;
      okey_q     <= rd_key;
      otag_q     <= rd_tag;
      ostatus_q  <= kdq_pkg::ST_ADDED;
      oremoved_q <= '0;
      oocc_q     <= kdq_pkg::COUNT_W'(cnt_q - n_q);
      olast_q    <= ((r_q + CW'(1)) == n_q);
    end else if (cmd_i.stat) begin
      kind_q     <= kdq_pkg::KIND_STATUS;
      okey_q     <= '0;
      otag_q     <= '0;
      ostatus_q  <= status_q;
      oremoved_q <= kdq_pkg::COUNT_W'(removed_q);
      oocc_q     <= kdq_pkg::COUNT_W'(cnt_q);
      olast_q    <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign out_key_o       = okey_q;
  assign out_tag_o       = otag_q;
  assign status_o        = ostatus_q;
  assign removed_count_o = oremoved_q;
  assign occupancy_o     = oocc_q;
  assign last_o          = olast_q;

endmodule

`default_nettype wire

>>> hdl/kdq_checker.sv
// ---------------------------------------------------------------------------
// Keyed delay queue checker
// Port-level assertions, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kdq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic [kdq_pkg::OP_W-1:0]      op_i,
  input wire logic [kdq_pkg::WAIT_W-1:0]    wait_time_i,
  input wire logic [kdq_pkg::KEY_W-1:0]     contact_key_i,
  input wire logic [kdq_pkg::TAG_W-1:0]     param_tag_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          kind_o,
  input wire logic [kdq_pkg::KEY_W-1:0]     out_key_o,
  input wire logic [kdq_pkg::TAG_W-1:0]     out_tag_o,
  input wire logic [kdq_pkg::STATUS_W-1:0]  status_o,
  input wire logic [kdq_pkg::COUNT_W-1:0]   removed_count_o,
  input wire logic [kdq_pkg::COUNT_W-1:0]   occupancy_o,
  input wire logic                          last_o
);

  `KDQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(out_key_o) && $stable(out_tag_o) &&
    $stable(status_o) && $stable(occupancy_o) && $stable(last_o),
    "stalled result word changed")

  `KDQ_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o,
    in_valid_i && $stable(op_i) && $stable(wait_time_i) && $stable(contact_key_i) &&
    $stable(param_tag_i),
    "stalled request word changed")

  `KDQ_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
    "second request taken while busy")

  `KDQ_ASSERT_IMP(a_status_word, clk_i, rst_ni,
    out_valid_o && (kind_o == kdq_pkg::KIND_STATUS),
    last_o && (out_key_o == '0) && (out_tag_o == '0), "malformed status word")

  `KDQ_ASSERT_IMP(a_dispatch_word, clk_i, rst_ni,
    out_valid_o && (kind_o == kdq_pkg::KIND_DISPATCH),
    (status_o == kdq_pkg::ST_ADDED) && (removed_count_o == '0), "malformed dispatch word")

endmodule

bind keyed_delay_queue_core kdq_checker u_kdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .op_i            (op_i),
  .wait_time_i     (wait_time_i),
  .contact_key_i   (contact_key_i),
  .param_tag_i     (param_tag_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .out_key_o       (out_key_o),
  .out_tag_o       (out_tag_o),
  .status_o        (status_o),
  .removed_count_o (removed_count_o),
  .occupancy_o     (occupancy_o),
  .last_o          (last_o)
);

`default_nettype wire

>>> test/keyed_delay_queue_core_tb.sv
// ---------------------------------------------------------------------------
// Keyed delay queue core testbench
// Drives requests on the input channel and checks every word on the result
// channel against a queue model kept in step at each accepted request.
// Covers field extremes, a full queue, long receiver hold-off and random
// traffic with bursty sending and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_delay_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = kdq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 200;
  localparam int unsigned RANDOM_ITEMS   = 225;

  localparam logic [kdq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    RX_READY,
    RX_RANDOM,
    RX_RUNS
  } rx_mode_e;

  typedef struct packed {
    logic [kdq_pkg::KEY_W-1:0]  key;
    logic [kdq_pkg::TAG_W-1:0]  tag;
    logic [kdq_pkg::TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    kdq_pkg::kind_e              kind;
    logic [kdq_pkg::KEY_W-1:0]   key;
    logic [kdq_pkg::TAG_W-1:0]   tag;
    kdq_pkg::status_e            status;
    logic [kdq_pkg::COUNT_W-1:0] removed;
    logic [kdq_pkg::COUNT_W-1:0] occupancy;
    logic                        last;
  } out_word_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [kdq_pkg::OP_W-1:0]     op_i          = '0;
  logic [kdq_pkg::WAIT_W-1:0]   wait_time_i   = '0;
  logic [kdq_pkg::KEY_W-1:0]    contact_key_i = '0;
  logic [kdq_pkg::TAG_W-1:0]    param_tag_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic                         kind_o;
  logic [kdq_pkg::KEY_W-1:0]    out_key_o;
  logic [kdq_pkg::TAG_W-1:0]    out_tag_o;
  logic [kdq_pkg::STATUS_W-1:0] status_o;
  logic [kdq_pkg::COUNT_W-1:0]  removed_count_o;
  logic [kdq_pkg::COUNT_W-1:0]  occupancy_o;
  logic                         last_o;

  entry_t      held_entries[$];
  logic [31:0] model_now = '0;
  out_word_t   expected_words[$];

  int          fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  int          burst_left    = 0;
  bit          sender_bursty = 1'b0;
  rx_mode_e    rx_mode       = RX_READY;
  logic        hold_req      = 1'b0;

  keyed_delay_queue_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .wait_time_i    (wait_time_i),
    .contact_key_i  (contact_key_i),
    .param_tag_i    (param_tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_key_o      (out_key_o),
    .out_tag_o      (out_tag_o),
    .status_o       (status_o),
    .removed_count_o(removed_count_o),
    .occupancy_o    (occupancy_o),
    .last_o         (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---- queue model -------------------------------------------------------

  // signed wrapped difference a - b is positive
  function automatic bit due_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != '0) && !d[31];
  endfunction

  function automatic kdq_pkg::status_e insert_entry(input logic [kdq_pkg::WAIT_W-1:0] w,
                                                    input logic [kdq_pkg::KEY_W-1:0]  k,
                                                    input logic [kdq_pkg::TAG_W-1:0]  t);
    entry_t e;
    int     pos;
    if (held_entries.size() >= DEPTH) return kdq_pkg::ST_FULL;
    e.key = k;
    e.tag = t;
    e.due = model_now + 32'(w);
    pos   = 0;
    while (pos < held_entries.size() && !due_after(held_entries[pos].due, e.due)) pos++;
    held_entries.insert(pos, e);
    return kdq_pkg::ST_ADDED;
  endfunction

  function automatic int drop_entries(input logic [kdq_pkg::KEY_W-1:0] k,
                                      input logic [kdq_pkg::TAG_W-1:0] t,
                                      input bit match_tag);
    entry_t kept[$];
    int     n;
    n = 0;
    foreach (held_entries[i]) begin
      if (held_entries[i].key == k && (!match_tag || held_entries[i].tag == t)) n++;
      else kept.push_back(held_entries[i]);
    end
    held_entries = kept;
    return n;
  endfunction

  function automatic bit key_held(input logic [kdq_pkg::KEY_W-1:0] k);
    foreach (held_entries[i]) if (held_entries[i].key == k) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_request(input logic [kdq_pkg::OP_W-1:0]   op,
                                 input logic [kdq_pkg::WAIT_W-1:0] w,
                                 input logic [kdq_pkg::KEY_W-1:0]  k,
                                 input logic [kdq_pkg::TAG_W-1:0]  t);
    out_word_t        r;
    out_word_t        fired[$];
    kdq_pkg::status_e st;
    int               removed;
    r       = '0;
    st      = kdq_pkg::ST_ADDED;
    removed = 0;
    if (op == kdq_pkg::OP_TICK) begin
      model_now = model_now + 32'd1;
      while (held_entries.size() != 0 && !due_after(held_entries[0].due, model_now)) begin
        r      = '0;
        r.kind = kdq_pkg::KIND_DISPATCH;
        r.key  = held_entries[0].key;
        r.tag  = held_entries[0].tag;
        fired.push_back(r);
        void'(held_entries.pop_front());
      end
      foreach (fired[i]) begin
        fired[i].occupancy = kdq_pkg::COUNT_W'(held_entries.size());
        fired[i].last      = (i == fired.size() - 1);
        expected_words.push_back(fired[i]);
      end
    end else if (op != OP_UNUSED) begin
      case (op)
        kdq_pkg::OP_ADD:        st = insert_entry(w, k, t);
        kdq_pkg::OP_ADD_ABSENT: st = key_held(k) ? kdq_pkg::ST_PRESENT : insert_entry(w, k, t);
        kdq_pkg::OP_REPLACE_KEY: begin
          removed = drop_entries(k, t, 1'b0);
          st      = insert_entry(w, k, t);
        end
        kdq_pkg::OP_REPLACE_KEY_TAG: begin
          removed = drop_entries(k, t, 1'b1);
          st      = insert_entry(w, k, t);
        end
        kdq_pkg::OP_REMOVE_KEY: begin
          removed = drop_entries(k, t, 1'b0);
          st      = kdq_pkg::ST_REMOVED;
        end
        default: begin
          removed = drop_entries(k, t, 1'b1);
          st      = kdq_pkg::ST_REMOVED;
        end
      endcase
      r.kind      = kdq_pkg::KIND_STATUS;
      r.status    = st;
      r.removed   = kdq_pkg::COUNT_W'(removed);
      r.occupancy = kdq_pkg::COUNT_W'(held_entries.size());
      r.last      = 1'b1;
      expected_words.push_back(r);
    end
  endtask

  // ---- stimulus ----------------------------------------------------------

  task automatic send_word(input logic [kdq_pkg::OP_W-1:0]   op,
                           input logic [kdq_pkg::WAIT_W-1:0] w,
                           input logic [kdq_pkg::KEY_W-1:0]  k,
                           input logic [kdq_pkg::TAG_W-1:0]  t);
    int gap;
    if (sender_bursty && burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    wait_time_i   <= w;
    contact_key_i <= k;
    param_tag_i   <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(op, w, k, t);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_field_extremes();
    rx_mode       = RX_READY;
    sender_bursty = 1'b0;
    send_word(kdq_pkg::OP_TICK, '0, '0, '0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(kdq_pkg::OP_ADD, '0, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(kdq_pkg::OP_ADD, 20'hFFFFF, '0, '0);
    send_word(kdq_pkg::OP_ADD_ABSENT, 20'd3, 16'hFFFF, 32'd9);
    send_word(kdq_pkg::OP_ADD_ABSENT, '0, 16'd1, 32'h1234);
    send_word(kdq_pkg::OP_REPLACE_KEY, '0, 16'hFFFF, 32'd5);
    send_word(kdq_pkg::OP_REPLACE_KEY_TAG, 20'd2, 16'd1, 32'h1234);
    send_word(kdq_pkg::OP_REMOVE_KEY_TAG, '0, '0, 32'd1);
    send_word(kdq_pkg::OP_TICK, '1, '1, '1);
    send_word(kdq_pkg::OP_TICK, '0, '0, '0);
    send_word(kdq_pkg::OP_REMOVE_KEY, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_queue();
    rx_mode = RX_RANDOM;
    for (int i = 0; i < DEPTH; i++) begin
      send_word(kdq_pkg::OP_ADD, kdq_pkg::WAIT_W'(i % 2), 16'd3, 32'(i));
    end
    send_word(kdq_pkg::OP_ADD_ABSENT, '0, 16'd9, '0);
    send_word(kdq_pkg::OP_ADD_ABSENT, '0, 16'd3, '0);
    send_word(kdq_pkg::OP_REPLACE_KEY_TAG, 20'd1, 16'd3, 32'd0);
    // every entry falls due on this tick
    send_word(kdq_pkg::OP_TICK, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_mode       = RX_READY;
    sender_bursty = 1'b0;
    hold_req      = 1'b1;
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_word(kdq_pkg::OP_ADD, kdq_pkg::WAIT_W'($urandom_range(1000, 20'hFFFFF)), 16'd7,
                $urandom);
    end
    send_word(kdq_pkg::OP_REMOVE_KEY, '0, 16'd7, '0);
    send_word(kdq_pkg::OP_TICK, '0, '0, '0);
    wait_drained();
  endtask

  task automatic random_word(output bit counted);
    int unsigned                pick;
    logic [kdq_pkg::OP_W-1:0]   op;
    logic [kdq_pkg::WAIT_W-1:0] w;
    logic [kdq_pkg::KEY_W-1:0]  k;
    logic [kdq_pkg::TAG_W-1:0]  t;
    pick = $urandom_range(0, 99);
    if (pick < 36)      op = kdq_pkg::OP_TICK;
    else if (pick < 56) op = kdq_pkg::OP_ADD;
    else if (pick < 64) op = kdq_pkg::OP_ADD_ABSENT;
    else if (pick < 72) op = kdq_pkg::OP_REPLACE_KEY;
    else if (pick < 80) op = kdq_pkg::OP_REPLACE_KEY_TAG;
    else if (pick < 88) op = kdq_pkg::OP_REMOVE_KEY;
    else if (pick < 96) op = kdq_pkg::OP_REMOVE_KEY_TAG;
    else                op = OP_UNUSED;
    w = ($urandom_range(0, 19) == 0) ? kdq_pkg::WAIT_W'($urandom)
                                     : kdq_pkg::WAIT_W'($urandom_range(0, 10));
    k = ($urandom_range(0, 9) == 0) ? kdq_pkg::KEY_W'($urandom)
                                    : kdq_pkg::KEY_W'($urandom_range(0, 5));
    t = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3));
    send_word(op, w, k, t);
    counted = (op != OP_UNUSED);
  endtask

  task automatic test_random_traffic();
    int sent;
    bit counted;
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_bursty = 1'b1; rx_mode = RX_RANDOM; end
        1: begin sender_bursty = 1'b0; rx_mode = RX_READY;  end
        default: begin sender_bursty = 1'b1; rx_mode = RX_RUNS; end
      endcase
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        random_word(counted);
        if (counted) sent++;
      end
    end
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  // ---- receiver stalls ---------------------------------------------------

  initial begin : rx_stall_gen
    int unsigned run_left;
    logic        run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      case (rx_mode)
        RX_READY:  out_stall_i <= 1'b0;
        RX_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 35);
        default: begin
          if (run_left == 0) begin
            run_stall = ~run_stall;
            run_left  = run_stall ? $urandom_range(1, 10) : $urandom_range(1, 6);
          end
          run_left--;
          out_stall_i <= run_stall;
        end
      endcase
    end
  end

  // ---- result checking ---------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0h key %0h tag %0h", kind_o, out_key_o, out_tag_o);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("out_key", want.key, out_key_o);
        check_field("out_tag", want.tag, out_tag_o);
        check_field("status", want.status, status_o);
        check_field("removed_count", want.removed, removed_count_o);
        check_field("occupancy", want.occupancy, occupancy_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_full_queue();
    test_backpressure();
    test_random_traffic();
    finish_run();
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/kdq_pkg.sv
hdl/kdq_ram.sv
hdl/kdq_ctrl.sv
hdl/kdq_dp.sv
hdl/keyed_delay_queue_core.sv
hdl/kdq_checker.sv
test/keyed_delay_queue_core_tb.sv
